FILE: rtl/lsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg: shared constants and types of the five-point laplacian
// widths, register indexes, input kinds and the neighbor flag bundle
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 8;

	// configuration register widths as the register map fixes them
	localparam int CFG_W_BITS    = 11;
	localparam int CFG_H_BITS    = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = CFG_W_BITS'(1024);
	localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = CFG_H_BITS'(1024);

	// counter and field widths
	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
	localparam int LAG_BITS = $clog2(MAX_WIDTH + 2);
	localparam int ROW_BITS = CFG_H_BITS + 1;
	localparam int LAP_BITS = PIXEL_BITS + 3;

	localparam logic signed [LAP_BITS-1:0] LAP_MAX = LAP_BITS'(4 * ((1 << PIXEL_BITS) - 1));
	localparam logic signed [LAP_BITS-1:0] LAP_MIN = -LAP_MAX;

	// input kinds carried on s_tuser
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// result word layout
	localparam int OUT_COL_LSB    = LAP_BITS;
	localparam int OUT_ROW_LSB    = LAP_BITS + COL_BITS;
	localparam int OUT_USED_BITS  = LAP_BITS + COL_BITS + CFG_H_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_USED_BITS + 7) / 8) * 8;
	localparam int IN_DATA_BITS   = ((PIXEL_BITS + 7) / 8) * 8;

	// which neighbors of the result pixel lie inside the frame
	typedef struct packed {
		logic left;
		logic right;
		logic up;
		logic down;
	} nbr_flags_t;

endpackage

FILE: rtl/laplacian_5point_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_5point_stencil: streaming five-point discrete laplacian
// zero-boundary stencil over a raster pixel stream, two line stores
// ----------------------------------------------------------------------------
// usage
//   input words arrive on s_* in raster order, one pixel per word; s_tuser
//   tells a pixel word from a drain word. after a frame the feeder sends
//   frame_width + 1 drain words to push out the remaining results.
//   result words leave on m_* with value, column and row in m_tdata and
//   m_tlast high on the frame's final pixel. after that word, and after any
//   register write, the next input word is pixel (0,0) of a new frame.
// throughput and result path
//   one word is taken every cycle while the output does not stall. the result for a pixel is produced by the
//   word frame_width + 1 places later in the stream, and shows on m_tvalid
//   after that word passes the ram read stage, then the result stage.
// reset
//   frame_width and frame_height reset to 1024, all counters clear. the line
//   stores are not cleared; no result ever uses an entry before it is written.
// stall
//   when m_tready is low the result word holds, the stage behind it holds,
//   and s_tready drops once that stage is full with a word that has a result.
// ----------------------------------------------------------------------------
module laplacian_5point_stencil (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [lsp_pkg::IN_DATA_BITS-1:0]      s_tdata,   // [7:0] pixel_value
	input  logic                                  s_tuser,   // [0] operation
	// result channel
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [lsp_pkg::OUT_DATA_BITS-1:0]     m_tdata,   // [10:0] laplacian_value,
	                                                          // [20:11] out_column,
	                                                          // [36:21] out_row, rest zero
	output logic                                  m_tlast,   // frame_last
	// configuration write port
	input  logic                                  cfg_wr_en,
	input  logic [lsp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [lsp_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

	import lsp_pkg::*;

	// configuration registers
	logic [CFG_W_BITS-1:0] frame_width_q;
	logic [CFG_H_BITS-1:0] frame_height_q;
	logic [WID_BITS-1:0]   eff_w;
	logic [CFG_H_BITS-1:0] eff_h;

	// stream position counters
	logic [COL_BITS-1:0]   in_col_q;
	logic [ROW_BITS-1:0]   in_row_q;
	logic [COL_BITS-1:0]   res_col_q;
	logic [CFG_H_BITS-1:0] res_row_q;
	logic [LAG_BITS-1:0]   lag_q;

	// accept-side decode
	logic                  accept;
	logic                  due;
	logic [WID_BITS-1:0]   in_col_inc;
	logic                  in_col_wrap;
	logic [WID_BITS-1:0]   res_col_inc;
	logic                  res_col_wrap;
	logic [CFG_H_BITS:0]   res_row_inc;
	logic                  last_a;
	nbr_flags_t            flags_a;
	logic [PIXEL_BITS-1:0] sample_a;

	// stage 1: item plus ram read data
	logic                  valid_s1;
	logic                  due_s1;
	logic                  last_s1;
	nbr_flags_t            flags_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic [COL_BITS-1:0]   rcol_s1;
	logic [CFG_H_BITS-1:0] rrow_s1;
	logic [PIXEL_BITS-1:0] sample_s1;
	logic                  cfwd_s1;
	logic [PIXEL_BITS-1:0] cfwd_data_s1;
	logic                  ufwd_s1;
	logic [PIXEL_BITS-1:0] ufwd_data_s1;
	logic                  adv_s1;

	// ram read data and resolved neighbor values
	logic [PIXEL_BITS-1:0] centre_rd;
	logic [PIXEL_BITS-1:0] upper_rd;
	logic [PIXEL_BITS-1:0] old_pix;
	logic [PIXEL_BITS-1:0] up_pix;

	// sliding window across the stream
	logic [PIXEL_BITS-1:0] win_left_q;
	logic [PIXEL_BITS-1:0] win_centre_q;
	logic [PIXEL_BITS-1:0] prev_sample_q;

	logic signed [LAP_BITS-1:0] lap;

	// stage 2: result word
	logic                       valid_s2;
	logic signed [LAP_BITS-1:0] lap_s2;
	logic [COL_BITS-1:0]        col_s2;
	logic [CFG_H_BITS-1:0]      row_s2;
	logic                       last_s2;
	logic                       out_free;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[CFG_W_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[CFG_H_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// zero width acts as one, oversize width clamps to the line store depth
	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = WID_BITS'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			eff_w = WID_BITS'(MAX_WIDTH);
		end else begin
			eff_w = WID_BITS'(frame_width_q);
		end
	end

	assign eff_h = (frame_height_q == '0) ? CFG_H_BITS'(1) : frame_height_q;

	// ------------------------------------------------------------------
	// position counters, all known before the word arrives
	// ------------------------------------------------------------------
	assign accept = s_tvalid && s_tready;

	// first result once width + 1 words have gone in
	assign due = ((WID_BITS+1)'(lag_q) == ((WID_BITS+1)'(eff_w) + (WID_BITS+1)'(1)));

	assign in_col_inc   = WID_BITS'(in_col_q) + WID_BITS'(1);
	assign in_col_wrap  = in_col_inc >= eff_w;
	assign res_col_inc  = WID_BITS'(res_col_q) + WID_BITS'(1);
	assign res_col_wrap = res_col_inc >= eff_w;
	assign res_row_inc  = (CFG_H_BITS+1)'(res_row_q) + (CFG_H_BITS+1)'(1);

	assign last_a = due && (res_row_inc == (CFG_H_BITS+1)'(eff_h)) && (res_col_inc == eff_w);

	assign flags_a.left  = res_col_q != '0;
	assign flags_a.right = res_col_inc < eff_w;
	assign flags_a.up    = res_row_q != '0;
	assign flags_a.down  = res_row_inc < (CFG_H_BITS+1)'(eff_h);

	// drains and words past the frame's last row fill their slot with zero
	assign sample_a = ((s_tuser == OP_PIXEL) && (in_row_q < ROW_BITS'(eff_h)))
		? s_tdata[PIXEL_BITS-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			res_col_q <= '0;
			res_row_q <= '0;
			lag_q     <= '0;
		end else if (cfg_wr_en || (accept && last_a)) begin
			// register write or frame end restarts the frame
			in_col_q  <= '0;
			in_row_q  <= '0;
			res_col_q <= '0;
			res_row_q <= '0;
			lag_q     <= '0;
		end else if (accept) begin
			if (in_col_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + ROW_BITS'(1);
			end else begin
				in_col_q <= in_col_inc[COL_BITS-1:0];
			end
			if (due) begin
				if (res_col_wrap) begin
					res_col_q <= '0;
					res_row_q <= res_row_inc[CFG_H_BITS-1:0];
				end else begin
					res_col_q <= res_col_inc[COL_BITS-1:0];
				end
			end else begin
				lag_q <= lag_q + LAG_BITS'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// line stores
	// centre store: latest sample per column, read at the input column
	// upper store: centre of the previous result row, read at result column
	// ------------------------------------------------------------------
	lsp_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_centre_store (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (sample_s1),
		.rd_en   (accept),
		.rd_addr (in_col_q),
		.rd_data (centre_rd)
	);

	lsp_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_upper_store (
		.clk     (clk),
		.wr_en   (adv_s1 && due_s1),
		.wr_addr (rcol_s1),
		.wr_data (win_centre_q),
		.rd_en   (accept),
		.rd_addr (res_col_q),
		.rd_data (upper_rd)
	);

	// ------------------------------------------------------------------
	// stage 1
	// ------------------------------------------------------------------
	assign out_free = !valid_s2 || m_tready;
	// words without a result never wait on the output
	assign adv_s1   = valid_s1 && (!due_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// forwarding covers a write to the address read in the same cycle,
	// which happens in one-pixel-wide frames and can also follow a restart
	always_ff @(posedge clk) begin
		if (accept) begin
			due_s1       <= due;
			last_s1      <= last_a;
			flags_s1     <= flags_a;
			col_s1       <= in_col_q;
			rcol_s1      <= res_col_q;
			rrow_s1      <= res_row_q;
			sample_s1    <= sample_a;
			cfwd_s1      <= adv_s1 && (col_s1 == in_col_q);
			cfwd_data_s1 <= sample_s1;
			ufwd_s1      <= adv_s1 && due_s1 && (rcol_s1 == res_col_q);
			ufwd_data_s1 <= win_centre_q;
		end
	end

	assign old_pix = cfwd_s1 ? cfwd_data_s1 : centre_rd;
	assign up_pix  = ufwd_s1 ? ufwd_data_s1 : upper_rd;

	// window: left and centre of the current result, down is the last sample
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_left_q    <= win_centre_q;
			win_centre_q  <= old_pix;
			prev_sample_q <= sample_s1;
		end
	end

	lsp_lap u_lap (
		.flags  (flags_s1),
		.left   (win_left_q),
		.right  (old_pix),
		.up     (up_pix),
		.down   (prev_sample_q),
		.centre (win_centre_q),
		.lap    (lap)
	);

	// ------------------------------------------------------------------
	// stage 2: output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && due_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && due_s1) begin
			lap_s2  <= lap;
			col_s2  <= rcol_s1;
			row_s2  <= rrow_s1;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {(OUT_DATA_BITS-OUT_USED_BITS)'(0), row_s2, col_s2, lap_s2};

endmodule

FILE: rtl/lsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/lsp_lap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_lap: five-point stencil arithmetic
// masks out-of-frame neighbors and forms their sum minus four times centre
// ----------------------------------------------------------------------------
module lsp_lap (
	input  lsp_pkg::nbr_flags_t                     flags,
	input  logic [lsp_pkg::PIXEL_BITS-1:0]          left,
	input  logic [lsp_pkg::PIXEL_BITS-1:0]          right,
	input  logic [lsp_pkg::PIXEL_BITS-1:0]          up,
	input  logic [lsp_pkg::PIXEL_BITS-1:0]          down,
	input  logic [lsp_pkg::PIXEL_BITS-1:0]          centre,
	output logic signed [lsp_pkg::LAP_BITS-1:0]     lap
);

	import lsp_pkg::*;

	logic [PIXEL_BITS-1:0] left_m, right_m, up_m, down_m;
	logic [PIXEL_BITS+1:0] nbr_sum;

	assign left_m  = flags.left  ? left  : '0;
	assign right_m = flags.right ? right : '0;
	assign up_m    = flags.up    ? up    : '0;
	assign down_m  = flags.down  ? down  : '0;

	assign nbr_sum = (PIXEL_BITS+2)'(left_m) + (PIXEL_BITS+2)'(right_m)
		+ (PIXEL_BITS+2)'(up_m) + (PIXEL_BITS+2)'(down_m);

	assign lap = $signed(LAP_BITS'(nbr_sum)) - $signed(LAP_BITS'({centre, 2'b00}));

endmodule

FILE: rtl/lsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_checker: port-level checks of the laplacian stencil
// watches the stream and configuration ports, bound to the top level
// ----------------------------------------------------------------------------
module lsp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lsp_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input logic                              m_tlast,
	input logic                              cfg_wr_en
);

	import lsp_pkg::*;

	logic signed [LAP_BITS-1:0] lap_val;
	logic [COL_BITS-1:0]        col_val;
	logic [CFG_H_BITS-1:0]      row_val;
	logic                       frame_start_q;

	assign lap_val = m_tdata[LAP_BITS-1:0];
	assign col_val = m_tdata[OUT_COL_LSB +: COL_BITS];
	assign row_val = m_tdata[OUT_ROW_LSB +: CFG_H_BITS];

	// next result word opens a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
		end else if (cfg_wr_en) begin
			frame_start_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			frame_start_q <= m_tlast;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	a_lap_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (lap_val >= LAP_MIN) && (lap_val <= LAP_MAX))
		else $error("laplacian value out of range");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_frame_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && frame_start_q |-> (col_val == '0) && (row_val == '0))
		else $error("frame does not start at pixel zero");

endmodule

bind laplacian_5point_stencil lsp_checker u_lsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_wr_en (cfg_wr_en)
);

FILE: bench/laplacian_5point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_5point_checker: result predictor and comparator for the stencil
// mirrors the line stores, window and counters, queues the laplacian words
// each input word produces and checks every result word against the oldest
// ----------------------------------------------------------------------------
module laplacian_5point_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [lsp_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input  logic                               s_tuser,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [lsp_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input  logic                               m_tlast,
	input  logic                               cfg_wr_en,
	input  logic [lsp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [lsp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output int                                 mismatches,
	output int                                 results_outstanding
);

	import lsp_pkg::*;

	typedef struct packed {
		logic signed [LAP_BITS-1:0] lap;
		logic [COL_BITS-1:0]        col;
		logic [CFG_H_BITS-1:0]      row;
		logic                       last;
	} lap_word_t;

	lap_word_t laplacian_q[$];

	logic [PIXEL_BITS-1:0] upper_line  [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] centre_line [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] win_left;
	logic [PIXEL_BITS-1:0] win_centre;
	int unsigned           in_col, in_row, res_col, res_row, lag_seen;
	logic [CFG_W_BITS-1:0] frame_w;
	logic [CFG_H_BITS-1:0] frame_h;
	int                    bad_count;
	lap_word_t             got, want;

	task automatic restart_frame();
		win_left   = '0;
		win_centre = '0;
		in_col     = 0;
		in_row     = 0;
		res_col    = 0;
		res_row    = 0;
		lag_seen   = 0;
	endtask

	// one input word through the stencil, queueing the result it completes
	task automatic stencil_advance(input logic op, input logic [PIXEL_BITS-1:0] pix);
		int unsigned           w, h, col, c, r;
		logic [PIXEL_BITS-1:0] sample, old, centre, left, right, up, down;
		int                    sum;
		logic                  done;
		lap_word_t             res;
		w = (frame_w == 0) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w);
		h = (frame_h == 0) ? 1 : frame_h;
		sample = (op == OP_PIXEL && in_row < h) ? pix : '0;
		col    = (in_col < w) ? in_col : 0;
		old    = centre_line[col];
		centre = win_centre;
		done   = 1'b0;
		if (lag_seen >= w + 1) begin
			r     = res_row;
			c     = (res_col < w) ? res_col : 0;
			left  = (c > 0) ? win_left : '0;
			right = (c + 1 < w) ? old : '0;
			up    = (r > 0) ? upper_line[c] : '0;
			down  = (r + 1 < h) ? centre_line[c] : '0;
			sum   = int'(left) + int'(right) + int'(up) + int'(down) - 4 * int'(centre);
			upper_line[c] = centre;
			done     = (r + 1 == h) && (c + 1 == w);
			res.lap  = sum[LAP_BITS-1:0];
			res.col  = c[COL_BITS-1:0];
			res.row  = r[CFG_H_BITS-1:0];
			res.last = done;
			laplacian_q.push_back(res);
			if (c + 1 >= w) begin
				res_col = 0;
				res_row = r + 1;
			end else begin
				res_col = c + 1;
			end
		end else begin
			lag_seen++;
		end
		centre_line[col] = sample;
		win_left   = centre;
		win_centre = old;
		if (col + 1 >= w) begin
			in_col = 0;
			in_row = (in_row + 1) & 32'h1FFFF;
		end else begin
			in_col = col + 1;
		end
		if (done)
			restart_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w = FRAME_WIDTH_RST;
			frame_h = FRAME_HEIGHT_RST;
			restart_frame();
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i]  = '0;
				centre_line[i] = '0;
			end
			laplacian_q.delete();
			bad_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.lap  = m_tdata[LAP_BITS-1:0];
				got.col  = m_tdata[OUT_COL_LSB +: COL_BITS];
				got.row  = m_tdata[OUT_ROW_LSB +: CFG_H_BITS];
				got.last = m_tlast;
				if (laplacian_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: unexpected result word lap %0d col %0d row %0d last %0b",
							$realtime, got.lap, got.col, got.row, got.last);
				end else begin
					want = laplacian_q.pop_front();
					if (got.lap !== want.lap || got.col !== want.col ||
						got.row !== want.row || got.last !== want.last) begin
						bad_count++;
						if (bad_count <= 10) begin
							$write("%0t: result mismatch, expected lap %0d col %0d row %0d",
								$realtime, want.lap, want.col, want.row);
							$write(" last %0b, got lap %0d col %0d row %0d",
								want.last, got.lap, got.col, got.row);
							$display(" last %0b", got.last);
						end
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  frame_w = cfg_wdata[CFG_W_BITS-1:0];
					REG_FRAME_HEIGHT: frame_h = cfg_wdata[CFG_H_BITS-1:0];
					default: ;
				endcase
				restart_frame();
			end
			if (s_tvalid && s_tready)
				stencil_advance(s_tuser, s_tdata[PIXEL_BITS-1:0]);
		end
		mismatches          <= bad_count;
		results_outstanding <= laplacian_q.size();
	end

endmodule

FILE: bench/laplacian_5point_stencil_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_5point_stencil_tb: stimulus and verdict for the laplacian stencil
// directed frames for the value extremes and frame edge cases, a cut-short
// frame at the largest width, then random frame sizes with gaps and stalls
// ----------------------------------------------------------------------------
module laplacian_5point_stencil_tb;
	import lsp_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;     // two pipeline stages plus margin
	localparam int HOLD_CYCLES   = 300;   // long result-side hold-off
	localparam int RANDOM_WORDS  = 270;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;   // [7:0] pixel_value
	logic                     s_tuser;   // [0] operation
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;   // [10:0] laplacian_value, [20:11] out_column,
	                                     // [36:21] out_row, rest zero
	logic                     m_tlast;   // frame_last
	logic                     cfg_wr_en;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	int mismatches;
	int results_outstanding;

	// stimulus, result-side and watchdog state; no_idle and hold_request are shared
	bit no_idle      = 1'b0;
	bit hold_request = 1'b0;
	int hold_left    = 0;
	int words_sent   = 0;
	int cycle_count  = 0;

	always #2 clk = ~clk;

	laplacian_5point_stencil dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	laplacian_5point_checker lap_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_tvalid            (s_tvalid),
		.s_tready            (s_tready),
		.s_tdata             (s_tdata),
		.s_tuser             (s_tuser),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.m_tlast             (m_tlast),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.mismatches          (mismatches),
		.results_outstanding (results_outstanding)
	);

	// pixel values lean toward the extremes now and then
	function automatic logic [PIXEL_BITS-1:0] pick_pixel();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return PIXEL_BITS'($urandom);
		endcase
	endfunction

	// offer one word, with random idle cycles ahead of it, and wait for the take
	task automatic push_word(input logic op, input logic [PIXEL_BITS-1:0] pix);
		while (!no_idle && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_DATA_BITS'(pix);
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// stop sending and let every predicted word come out, then the pipe settle;
	// the first edge lets the checker count the last word taken
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// well-formed frame: every pixel, a rare drain inside, then width + 1
	// trailing words, mostly drains and some stray pixels that count as drains
	task automatic send_frame(input int w, input int h);
		for (int i = 0; i < w * h; i++) begin
			if ($urandom_range(31) == 0)
				push_word(OP_DRAIN, PIXEL_BITS'($urandom));
			else
				push_word(OP_PIXEL, pick_pixel());
		end
		for (int i = 0; i <= w; i++)
			push_word(($urandom_range(4) == 0) ? OP_PIXEL : OP_DRAIN, PIXEL_BITS'($urandom));
	endtask

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= no_idle || ($urandom_range(99) >= 21);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("laplacian_5point_stencil test failed");
		$finish;
	end

	initial begin
		logic [CFG_W_BITS-1:0]    w_cfg;
		logic [CFG_H_BITS-1:0]    h_cfg;
		logic [CFG_DATA_BITS-1:0] junk;
		int                       w_eff, h_eff, rand_start;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= OP_PIXEL;
		s_tdata   <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 checkerboard: the centre sees four full neighbors (top value),
		// the edge pixels see none (bottom value)
		write_reg(REG_FRAME_WIDTH, 16'h0003);
		write_reg(REG_FRAME_HEIGHT, 16'h0003);
		push_word(OP_PIXEL, 8'h00);
		push_word(OP_PIXEL, 8'hFF);
		push_word(OP_PIXEL, 8'h00);
		push_word(OP_PIXEL, 8'hFF);
		push_word(OP_PIXEL, 8'h00);
		push_word(OP_PIXEL, 8'hFF);
		// sender pauses mid-frame until the block has nothing owed
		drain_results();
		// drain inside the frame stands for a zero pixel, its data ignored
		push_word(OP_DRAIN, 8'hFF);
		push_word(OP_PIXEL, 8'hFF);
		push_word(OP_PIXEL, 8'h00);
		// a pixel past the frame end acts as a drain
		push_word(OP_PIXEL, 8'h5A);
		push_word(OP_DRAIN, 8'h00);
		push_word(OP_DRAIN, 8'h00);
		push_word(OP_DRAIN, 8'h00);

		// zero width and zero height count as one: a lone pixel frame,
		// upper data bits of the width write are junk and must be dropped
		write_reg(REG_FRAME_WIDTH, 16'hF800);
		write_reg(REG_FRAME_HEIGHT, 16'h0000);
		push_word(OP_PIXEL, 8'hFF);
		push_word(OP_DRAIN, 8'h00);
		push_word(OP_DRAIN, 8'h00);

		// width above the maximum clamps to 1024, tallest height; the frame
		// is cut short by the next register write. a run with no idling on
		// either side sits in the first row, and the long result hold-off
		// starts as results begin, so the pipe fills and the input stalls
		// while words keep coming
		write_reg(REG_FRAME_WIDTH, 16'hFFFF);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		repeat (200) push_word(OP_PIXEL, pick_pixel());
		no_idle = 1'b1;
		repeat (400) push_word(OP_PIXEL, pick_pixel());
		no_idle = 1'b0;
		repeat (424) push_word(OP_PIXEL, pick_pixel());
		hold_request = 1'b1;
		repeat (40) push_word(OP_PIXEL, pick_pixel());

		// random frame sizes, mostly well-formed frames with some noise
		rand_start = words_sent;
		while (words_sent - rand_start < RANDOM_WORDS) begin
			case ($urandom_range(11))
				0:       w_cfg = '0;
				1:       w_cfg = 1;
				2:       w_cfg = 2;
				3:       w_cfg = CFG_W_BITS'($urandom_range(13, 40));
				default: w_cfg = CFG_W_BITS'($urandom_range(2, 12));
			endcase
			case ($urandom_range(9))
				0:       h_cfg = '0;
				1:       h_cfg = 1;
				2:       h_cfg = '1;
				default: h_cfg = CFG_H_BITS'($urandom_range(2, 6));
			endcase
			junk = CFG_DATA_BITS'($urandom);
			write_reg(REG_FRAME_WIDTH, {junk[CFG_DATA_BITS-1:CFG_W_BITS], w_cfg});
			write_reg(REG_FRAME_HEIGHT, h_cfg);
			w_eff = (w_cfg == 0) ? 1 : ((w_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(w_cfg));
			h_eff = (h_cfg == 0) ? 1 : int'(h_cfg);

			if (h_cfg == '1) begin
				// endless frame: a stretch of rows, aborted by the next write
				repeat ($urandom_range(10, 80)) push_word(OP_PIXEL, pick_pixel());
			end else begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(9))
						0: repeat ($urandom_range(1, 20))
							push_word(logic'($urandom_range(1)), PIXEL_BITS'($urandom));
						1: repeat ($urandom_range(0, w_eff * h_eff))
							push_word(OP_PIXEL, pick_pixel());
						default: send_frame(w_eff, h_eff);
					endcase
				end
			end
		end
		no_idle = 1'b0;

		drain_results();
		if (mismatches == 0)
			$display("laplacian_5point_stencil test passed");
		else
			$display("laplacian_5point_stencil test failed");
		$finish;
	end

endmodule
